// ===== sv/jsu_pkg.sv =====
`default_nettype none

package jsu_pkg;

   // request and result payloads
   typedef struct packed {
      logic [7:0] in_byte;
      logic       terminator;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       run_last;
      logic [1:0] status;
   } rsp_type;

   // end-of-string status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_UNEXPECTED = 2'd1;
   localparam logic [1:0] ST_UNICODE    = 2'd2;

   // command queue between the front and the back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // one command: up to three bytes, or the end result
   typedef struct packed {
      logic       is_end;
      logic [1:0] status;
      logic [1:0] count;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } cmd_type;

   // utf-8 encoding constants
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

endpackage

`default_nettype wire

// ===== sv/jsu_front.sv =====
`default_nettype none

module jsu_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire jsu_pkg::req_type req,
   output logic                  push,
   output jsu_pkg::cmd_type      cmd
);

   localparam logic [2:0] MODE_NORMAL = 3'd0;
   localparam logic [2:0] MODE_ESCAPE = 3'd1;
   localparam logic [2:0] MODE_HEX0   = 3'd2;
   localparam logic [2:0] MODE_HEX1   = 3'd3;
   localparam logic [2:0] MODE_HEX2   = 3'd4;
   localparam logic [2:0] MODE_HEX3   = 3'd5;
   localparam logic [2:0] MODE_ERROR  = 3'd6;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_U         = 8'h75;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] cp_ff, cp_in;
   logic [1:0]  err_ff, err_in;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cp_next;
   logic [7:0]  c;

   // hex digit decode, either case
   always_comb begin
      c       = req.in_byte;
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         hex_val = 4'(c - 8'h30);
      end else if (c inside {[8'h61:8'h66]}) begin
         hex_val = 4'(c - 8'h57);
      end else if (c inside {[8'h41:8'h46]}) begin
         hex_val = 4'(c - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
      cp_next = {cp_ff[11:0], hex_val};
   end

   // escape state machine and command build
   always_comb begin
      mode_in = mode_ff;
      cp_in   = cp_ff;
      err_in  = err_ff;
      push    = 1'b0;
      cmd     = '0;
      if (accept) begin
         if (req.terminator) begin
            push       = 1'b1;
            cmd.is_end = 1'b1;
            if (mode_ff == MODE_NORMAL) begin
               cmd.status = err_ff;
            end else if (mode_ff == MODE_ESCAPE) begin
               cmd.status = jsu_pkg::ST_UNEXPECTED;
            end else if (mode_ff inside {[MODE_HEX0:MODE_HEX3]}) begin
               cmd.status = jsu_pkg::ST_UNICODE;
            end else begin
               cmd.status = err_ff;
            end
            mode_in = MODE_NORMAL;
            cp_in   = '0;
            err_in  = jsu_pkg::ST_OK;
         end else begin
            case (mode_ff)
               MODE_NORMAL: begin
                  if (c == CHAR_BACKSLASH) begin
                     mode_in = MODE_ESCAPE;
                  end else begin
                     push      = 1'b1;
                     cmd.count = 2'd1;
                     cmd.byte0 = c;
                  end
               end
               MODE_ESCAPE: begin
                  mode_in   = MODE_NORMAL;
                  push      = 1'b1;
                  cmd.count = 2'd1;
                  case (c)
                     CHAR_BACKSLASH: cmd.byte0 = CHAR_BACKSLASH;
                     CHAR_QUOTE:     cmd.byte0 = CHAR_QUOTE;
                     CHAR_SLASH:     cmd.byte0 = CHAR_SLASH;
                     CHAR_B:         cmd.byte0 = 8'h08;
                     CHAR_F:         cmd.byte0 = 8'h0C;
                     CHAR_N:         cmd.byte0 = 8'h0A;
                     CHAR_R:         cmd.byte0 = 8'h0D;
                     CHAR_T:         cmd.byte0 = 8'h09;
                     CHAR_U: begin
                        push    = 1'b0;
                        cp_in   = '0;
                        mode_in = MODE_HEX0;
                     end
                     default: begin
                        push    = 1'b0;
                        err_in  = jsu_pkg::ST_UNEXPECTED;
                        mode_in = MODE_ERROR;
                     end
                  endcase
               end
               MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                  if (!hex_ok) begin
                     err_in  = jsu_pkg::ST_UNICODE;
                     mode_in = MODE_ERROR;
                  end else begin
                     cp_in = cp_next;
                     if (mode_ff == MODE_HEX3) begin
                        mode_in = MODE_NORMAL;
                        push    = 1'b1;
                        // utf-8 encode the gathered code point
                        if (cp_next[15:7] == '0) begin
                           cmd.count = 2'd1;
                           cmd.byte0 = cp_next[7:0];
                        end else if (cp_next[15:11] == '0) begin
                           cmd.count = 2'd2;
                           cmd.byte0 = jsu_pkg::UTF8_LEAD2 | {3'b000, cp_next[10:6]};
                           cmd.byte1 = jsu_pkg::UTF8_CONT | {2'b00, cp_next[5:0]};
                        end else begin
                           cmd.count = 2'd3;
                           cmd.byte0 = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp_next[15:12]};
                           cmd.byte1 = jsu_pkg::UTF8_CONT | {2'b00, cp_next[11:6]};
                           cmd.byte2 = jsu_pkg::UTF8_CONT | {2'b00, cp_next[5:0]};
                        end
                     end else begin
                        mode_in = mode_ff + 3'd1;
                     end
                  end
               end
               default: begin
                  // error state: drop bytes until the terminator
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         cp_ff   <= '0;
         err_ff  <= jsu_pkg::ST_OK;
      end else begin
         mode_ff <= mode_in;
         cp_ff   <= cp_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/jsu_queue.sv =====
`default_nettype none

module jsu_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire jsu_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output jsu_pkg::cmd_type      head
);

   jsu_pkg::cmd_type entry_ff [jsu_pkg::QUEUE_DEPTH];

   logic [jsu_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QUEUE_AW:0]   count_ff, count_in;

   localparam logic [jsu_pkg::QUEUE_AW-1:0] LAST_PTR = jsu_pkg::QUEUE_AW'(jsu_pkg::QUEUE_DEPTH - 1);
   localparam logic [jsu_pkg::QUEUE_AW:0]   FULL_CNT = (jsu_pkg::QUEUE_AW + 1)'(jsu_pkg::QUEUE_DEPTH);

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/jsu_back.sv =====
`default_nettype none

module jsu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             empty,
   input  wire jsu_pkg::cmd_type head,
   output logic                  pop,
   input  wire logic             rsp_stall,
   output logic                  rsp_valid,
   output jsu_pkg::rsp_type      rsp_payload
);

   logic             valid_ff, valid_in;
   jsu_pkg::rsp_type rsp_ff, rsp_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load;
   logic             last;
   logic [7:0]       sel_byte;

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   // pick the byte of the current command
   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.byte0;
         2'd1:    sel_byte = head.byte1;
         default: sel_byte = head.byte2;
      endcase
      last = head.is_end || (idx_ff == head.count - 2'd1);
   end

   // output register refill
   always_comb begin
      load     = !valid_ff || !rsp_stall;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            rsp_in.out_byte = head.is_end ? 8'h00 : sel_byte;
            rsp_in.has_byte = !head.is_end;
            rsp_in.run_last = last;
            rsp_in.status   = head.is_end ? head.status : jsu_pkg::ST_OK;
            pop             = last;
            idx_in          = last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== sv/json_string_unescape_unit.sv =====
// JSON string unescape unit: takes the raw bytes of a JSON string body, one request per
// byte, then a terminator request, and returns decoded bytes with backslash and \uXXXX
// escapes (UTF-8 encoded, one to three bytes) resolved, followed by one end result whose
// status tells whether the string was well formed; on a nonzero status the string's bytes
// must be discarded. Requests are taken one per cycle, sustained while rsp_stall is low;
// the back end sends one result per cycle unless stalled, so a \u escape's three output
// bytes are covered by the six input bytes of the escape. A four-entry command queue
// between the decoder and the output stage absorbs those bursts and downstream stalls;
// req_stall rises only when it is full. Results pass the queue, then the output register.
`default_nettype none

module json_string_unescape_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire jsu_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output jsu_pkg::rsp_type      rsp_payload
);

   logic             accept;
   logic             push;
   jsu_pkg::cmd_type push_cmd;
   logic             pop;
   logic             full;
   logic             empty;
   jsu_pkg::cmd_type head;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   // decoder front end
   jsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .cmd    (push_cmd)
   );

   // command queue
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   // result back end
   jsu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .empty       (empty),
      .head        (head),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== sv/jsu_checker.sv =====
`default_nettype none

module jsu_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire jsu_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // the end result is always the last one of its request and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_byte |->
         rsp_payload.run_last && rsp_payload.out_byte == 8'h00)
      else $error("malformed end result");

   // data results carry an ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.has_byte |-> rsp_payload.status == jsu_pkg::ST_OK)
      else $error("data result with error status");

   // status is a defined code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == jsu_pkg::ST_OK ||
         rsp_payload.status == jsu_pkg::ST_UNEXPECTED ||
         rsp_payload.status == jsu_pkg::ST_UNICODE)
      else $error("undefined status code");

   // no result right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind json_string_unescape_unit jsu_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
